@@ sv/itfp_pkg.sv @@
// itfp_pkg: shared types and constants of the integer text field parser
// no dependencies; used by every module of the parser
`default_nettype none

package itfp_pkg;

    typedef enum logic [1:0] {
        B_AUTO = 2'd0,
        B_DEC  = 2'd1,
        B_HEX  = 2'd2,
        B_OCT  = 2'd3
    } base_t;

    localparam logic [1:0] REG_BASE_MODE   = 2'd0;
    localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH   = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic       eoi;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_hex;
        logic [3:0] dval;
    } char_class_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

`default_nettype wire

@@ sv/itfp_fifo.sv @@
// itfp_fifo: two-entry queue of data beats
// depends on itfp_pkg for the status struct
`default_nettype none

module itfp_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr,
    input  wire logic [WIDTH-1:0]   wr_data,
    input  wire logic               rd,
    output logic [WIDTH-1:0]        rd_data,
    output itfp_pkg::fifo_status_t  status
);

    logic [WIDTH-1:0] mem_reg [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             do_wr;
    logic             do_rd;

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/itfp_front.sv @@
// itfp_front: classifies one input character into digit value and markers
// depends on itfp_pkg for the class struct and character constants
`default_nettype none

module itfp_front (
    input  wire logic              [7:0] ch,
    input  wire logic                    end_of_input,
    output itfp_pkg::char_class_t        cls
);

    always_comb
    begin
        cls          = '0;
        cls.eoi      = end_of_input;
        cls.is_minus = (ch == itfp_pkg::CH_MINUS);
        cls.is_zero  = (ch == itfp_pkg::CH_ZERO);
        cls.is_x     = (ch == itfp_pkg::CH_LOW_X) || (ch == itfp_pkg::CH_UP_X);
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            cls.is_hex = 1'b1;
            cls.dval   = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            cls.is_hex = 1'b1;
            cls.dval   = 4'(ch - 8'h57);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            cls.is_hex = 1'b1;
            cls.dval   = 4'(ch - 8'h37);
        end
    end

endmodule

`default_nettype wire

@@ sv/itfp_back.sv @@
// itfp_back: field state machine, digit accumulation and result forming
// depends on itfp_pkg for the class struct and base codes
`default_nettype none

module itfp_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire itfp_pkg::char_class_t    cls,
    input  wire itfp_pkg::fifo_status_t   mid_status,
    input  wire itfp_pkg::fifo_status_t   out_status,
    input  wire itfp_pkg::base_t          base_mode,
    input  wire logic                     signed_mode,
    input  wire logic [7:0]               max_width,
    output logic                          mid_pop,
    output logic                          out_push,
    output logic [VALUE_BITS+1:0]         out_data
);

    typedef enum logic [3:0] {
        PH_START      = 4'b0001,
        PH_FIRST      = 4'b0010,
        PH_AFTER_ZERO = 4'b0100,
        PH_DIGITS     = 4'b1000
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [7:0]            rem_reg;
    logic [7:0]            rem_next;
    itfp_pkg::base_t       base_reg;
    itfp_pkg::base_t       base_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic                  emit;
    logic                  consumed;
    logic                  done;
    logic                  digit_ok;
    logic [VALUE_BITS-1:0] acc_mul;
    logic [8:0]            uw;
    logic                  act;

    function automatic logic [8:0] use_width(input logic [7:0] r);
        logic [7:0] n;
        n = (r == 8'd0) ? r : r - 8'd1;
        return {(r != 8'd0) && (n == 8'd0), n};
    endfunction

    assign act      = !mid_status.empty && !out_status.full;
    assign mid_pop  = act;
    assign out_push = act && emit;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        consumed   = 1'b0;
        done       = 1'b0;
        digit_ok   = 1'b0;
        acc_mul    = '0;
        uw         = '0;

        // field start
        if (phase_next == PH_START)
        begin
            rem_next  = max_width;
            base_next = base_mode;
            acc_next  = '0;
            neg_next  = 1'b0;
            seen_next = 1'b0;
            if (cls.eoi)
            begin
                emit = 1'b1;
                done = 1'b1;
            end
            else
            begin
                phase_next = PH_FIRST;
                if (signed_mode && cls.is_minus)
                begin
                    neg_next = 1'b1;
                    done     = 1'b1;
                    uw       = use_width(rem_next);
                    rem_next = uw[7:0];
                    emit     = uw[8];
                    consumed = uw[8];
                end
            end
        end

        // prefix handling
        if (!done)
        begin
            if (phase_next == PH_FIRST)
            begin
                if (cls.eoi)
                begin
                    emit = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    if (base_next == itfp_pkg::B_AUTO)
                    begin
                        if (cls.is_zero)
                        begin
                            seen_next  = 1'b1;
                            base_next  = itfp_pkg::B_OCT;
                            phase_next = PH_AFTER_ZERO;
                            done       = 1'b1;
                            uw         = use_width(rem_next);
                            rem_next   = uw[7:0];
                            emit       = uw[8];
                            consumed   = uw[8];
                        end
                        else
                        begin
                            base_next = itfp_pkg::B_DEC;
                        end
                    end
                    if (!done)
                    begin
                        phase_next = PH_DIGITS;
                    end
                end
            end
            else if (phase_next == PH_AFTER_ZERO)
            begin
                if (cls.eoi)
                begin
                    emit = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    phase_next = PH_DIGITS;
                    if (cls.is_x)
                    begin
                        base_next = itfp_pkg::B_HEX;
                        done      = 1'b1;
                        uw        = use_width(rem_next);
                        rem_next  = uw[7:0];
                        emit      = uw[8];
                        consumed  = uw[8];
                    end
                end
            end
        end

        // digit accumulation
        unique case (base_next)
            itfp_pkg::B_HEX:
            begin
                digit_ok = cls.is_hex;
                acc_mul  = acc_next << 4;
            end
            itfp_pkg::B_OCT:
            begin
                digit_ok = cls.is_hex && (cls.dval < 4'd8);
                acc_mul  = acc_next << 3;
            end
            default:
            begin
                digit_ok = cls.is_hex && (cls.dval < 4'd10);
                acc_mul  = (acc_next << 3) + (acc_next << 1);
            end
        endcase

        if (!done)
        begin
            if (cls.eoi || !digit_ok)
            begin
                emit = 1'b1;
            end
            else
            begin
                acc_next  = acc_mul + VALUE_BITS'(cls.dval);
                seen_next = 1'b1;
                uw        = use_width(rem_next);
                rem_next  = uw[7:0];
                emit      = uw[8];
                consumed  = uw[8];
            end
        end

        out_data = {(neg_next ? ({VALUE_BITS{1'b0}} - acc_next) : acc_next),
                    consumed, !seen_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            rem_reg   <= 8'd0;
            base_reg  <= itfp_pkg::B_DEC;
            seen_reg  <= 1'b0;
        end
        else if (act)
        begin
            if (emit)
            begin
                phase_reg <= PH_START;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                rem_reg   <= max_width;
                seen_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                rem_reg   <= rem_next;
                seen_reg  <= seen_next;
            end
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/integer_text_field_parser.sv @@
// integer_text_field_parser: top level, configuration registers and queues
// depends on itfp_pkg, itfp_front, itfp_fifo and itfp_back
`default_nettype none

// Takes character beats and parses one integer field at a time, in decimal,
// hex, octal or with automatic 0 / 0x prefix detection, with an optional
// leading minus and a width limit. Sustained rate is one character per clock
// while the result queue has room; a result enters the output queue as the
// back end takes the beat ending its field. The rate is set by the back end's
// combinational multiply-add by the base. A two-entry queue sits between
// classifier and back end and another holds results, so either side may
// stall alone. Configuration is latched at the first character of each field.

module integer_text_field_parser #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            ch,
    input  wire logic                  end_of_input,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [VALUE_BITS-1:0]      value,
    output logic                       terminator_consumed,
    output logic                       no_digits,
    input  wire logic                  wr_en,
    input  wire logic [1:0]            wr_index,
    input  wire logic [7:0]            wr_data
);

    localparam int ClsBits = $bits(itfp_pkg::char_class_t);
    localparam int ResBits = VALUE_BITS + 2;

    itfp_pkg::base_t        base_mode_reg;
    logic                   signed_mode_reg;
    logic [7:0]             max_width_reg;
    itfp_pkg::char_class_t  front_cls;
    logic [ClsBits-1:0]     mid_rd_data;
    itfp_pkg::char_class_t  mid_cls;
    itfp_pkg::fifo_status_t mid_status;
    itfp_pkg::fifo_status_t out_status;
    logic                   mid_pop;
    logic                   out_push;
    logic [ResBits-1:0]     out_wr_data;
    logic [ResBits-1:0]     out_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg   <= itfp_pkg::B_AUTO;
            signed_mode_reg <= 1'b1;
            max_width_reg   <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                itfp_pkg::REG_BASE_MODE:   base_mode_reg   <= itfp_pkg::base_t'(wr_data[1:0]);
                itfp_pkg::REG_SIGNED_MODE: signed_mode_reg <= wr_data[0];
                itfp_pkg::REG_MAX_WIDTH:   max_width_reg   <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    itfp_front u_front (
        .ch           (ch),
        .end_of_input (end_of_input),
        .cls          (front_cls)
    );

    itfp_fifo #(
        .WIDTH (ClsBits)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_data (front_cls),
        .rd      (mid_pop),
        .rd_data (mid_rd_data),
        .status  (mid_status)
    );

    assign mid_cls = itfp_pkg::char_class_t'(mid_rd_data);
    assign full    = mid_status.full;

    itfp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cls         (mid_cls),
        .mid_status  (mid_status),
        .out_status  (out_status),
        .base_mode   (base_mode_reg),
        .signed_mode (signed_mode_reg),
        .max_width   (max_width_reg),
        .mid_pop     (mid_pop),
        .out_push    (out_push),
        .out_data    (out_wr_data)
    );

    itfp_fifo #(
        .WIDTH (ResBits)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (out_push),
        .wr_data (out_wr_data),
        .rd      (pop),
        .rd_data (out_rd_data),
        .status  (out_status)
    );

    assign empty               = out_status.empty;
    assign value               = out_rd_data[ResBits-1:2];
    assign terminator_consumed = out_rd_data[1];
    assign no_digits           = out_rd_data[0];

endmodule

`default_nettype wire

@@ sv/itfp_checker.sv @@
// itfp_checker: port-level checks of the integer text field parser
// no package use; bound to integer_text_field_parser at the end of this file
`default_nettype none

module itfp_checker #(
    parameter int VALUE_BITS = 32
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  push,
    input wire logic                  full,
    input wire logic                  empty,
    input wire logic                  pop,
    input wire logic [VALUE_BITS-1:0] value,
    input wire logic                  terminator_consumed,
    input wire logic                  no_digits
);

    // both queues come out of reset drained
    a_reset_drained: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // a waiting result beat holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value)
            && $stable(terminator_consumed) && $stable(no_digits)))
        else $error("waiting result changed");

    // the input queue fills only through an accepted beat
    a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted beat");

    // a field without digits always reads as zero
    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && no_digits) |-> (value == '0))
        else $error("nonzero value with no digits");

endmodule

bind integer_text_field_parser itfp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_itfp_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .empty               (empty),
    .pop                 (pop),
    .value               (value),
    .terminator_consumed (terminator_consumed),
    .no_digits           (no_digits)
);

`default_nettype wire
